### rtl/selection_sort_engine_core_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the selection sort engine
// uses the clk and rst_n names of the including module
// ----------------------------------------------------------------------------
`ifndef SELECTION_SORT_ENGINE_CORE_ASSERT_SVH
`define SELECTION_SORT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define SSORT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSORT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssort_pkg.sv
// ----------------------------------------------------------------------------
// ssort_pkg
// shared constants, controller states and command/status structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssort_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [2:0] {
        S_COLLECT,
        S_PASS_START,
        S_SCAN,
        S_DRAIN,
        S_SWAP_A,
        S_SWAP_B,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

    typedef struct packed {
        logic store_in;
        logic clr_set;
        logic pass_init;
        logic scan_rd;
        logic swap_a;
        logic swap_b;
        logic emit_init;
        logic emit_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic single;
        logic scan_end;
        logic outer_end;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### rtl/ssort_ctrl.sv
// ----------------------------------------------------------------------------
// ssort_ctrl
// sequencer for collect, selection passes, swap and emit phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssort_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_last,
    input  wire ssort_pkg::sts_t sts,
    output ssort_pkg::cmd_t      cmd,
    output logic                 in_stall
);

    ssort_pkg::state_t state_reg;
    ssort_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssort_pkg::S_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ssort_pkg::S_COLLECT:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.store_in = 1'b1;
                    if (in_last)
                    begin
                        state_next = ssort_pkg::S_PASS_START;
                    end
                end
            end
            ssort_pkg::S_PASS_START:
            begin
                if (sts.single)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ssort_pkg::S_EMIT_RD;
                end
                else
                begin
                    cmd.pass_init = 1'b1;
                    state_next    = ssort_pkg::S_SCAN;
                end
            end
            ssort_pkg::S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = ssort_pkg::S_DRAIN;
                end
            end
            // last compare lands at the end of this cycle
            ssort_pkg::S_DRAIN:
            begin
                state_next = ssort_pkg::S_SWAP_A;
            end
            ssort_pkg::S_SWAP_A:
            begin
                cmd.swap_a = 1'b1;
                state_next = ssort_pkg::S_SWAP_B;
            end
            ssort_pkg::S_SWAP_B:
            begin
                cmd.swap_b = 1'b1;
                if (sts.outer_end)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ssort_pkg::S_EMIT_RD;
                end
                else
                begin
                    state_next = ssort_pkg::S_SCAN;
                end
            end
            ssort_pkg::S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ssort_pkg::S_EMIT_LD;
            end
            ssort_pkg::S_EMIT_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.scan_end)
                    begin
                        cmd.clr_set = 1'b1;
                        state_next  = ssort_pkg::S_COLLECT;
                    end
                    else
                    begin
                        state_next = ssort_pkg::S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ssort_pkg::S_COLLECT;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ssort_dp.sv
// ----------------------------------------------------------------------------
// ssort_dp
// element store, index counters, running minimum and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "selection_sort_engine_core_assert.svh"

module ssort_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ssort_pkg::cmd_t                     cmd,
    output ssort_pkg::sts_t                          sts,
    input  wire logic signed [ssort_pkg::DATA_W-1:0] value,
    input  wire logic                                out_stall,
    output logic                                     out_valid,
    output logic signed [ssort_pkg::DATA_W-1:0]      value_res,
    output logic                                     last_res,
    output logic                                     overflow
);

    logic [ssort_pkg::DATA_W-1:0] mem [ssort_pkg::MAX_ELEMENTS];

    logic [ssort_pkg::CNT_W-1:0] count_reg, count_next;
    logic [ssort_pkg::IDX_W-1:0] outer_reg, outer_next;
    logic [ssort_pkg::IDX_W-1:0] scan_reg, scan_next;
    logic [ssort_pkg::IDX_W-1:0] min_pos_reg, min_pos_next;
    logic                        dropped_reg, dropped_next;
    logic                        rd_vld_reg, rd_first_reg;
    logic [ssort_pkg::IDX_W-1:0] rd_pos_reg;

    logic signed [ssort_pkg::DATA_W-1:0] rd_data_reg;
    logic signed [ssort_pkg::DATA_W-1:0] min_val_reg, min_val_next;
    logic signed [ssort_pkg::DATA_W-1:0] outer_val_reg, outer_val_next;

    logic                                out_valid_reg, out_valid_next;
    logic signed [ssort_pkg::DATA_W-1:0] value_res_reg;
    logic                                last_res_reg, overflow_reg;

    logic                                full;
    logic [ssort_pkg::IDX_W-1:0]         last_idx;
    logic                                mem_we, mem_re;
    logic [ssort_pkg::IDX_W-1:0]         mem_wa;
    logic [ssort_pkg::DATA_W-1:0]        mem_wd;

    assign full     = (count_reg == ssort_pkg::CNT_W'(ssort_pkg::MAX_ELEMENTS));
    assign last_idx = ssort_pkg::IDX_W'(count_reg - ssort_pkg::CNT_W'(1));

    assign sts.single    = (last_idx == '0);
    assign sts.scan_end  = (scan_reg == last_idx);
    assign sts.outer_end = ((outer_reg + ssort_pkg::IDX_W'(1)) == last_idx);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // single write port shared by collect and the two swap cycles
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = scan_reg;
        mem_wd = value;
        priority if (cmd.store_in)
        begin
            mem_we = !full;
            mem_wa = count_reg[ssort_pkg::IDX_W-1:0];
            mem_wd = value;
        end
        else if (cmd.swap_a)
        begin
            mem_we = 1'b1;
            mem_wa = min_pos_reg;
            mem_wd = outer_val_reg;
        end
        else if (cmd.swap_b)
        begin
            mem_we = 1'b1;
            mem_wa = outer_reg;
            mem_wd = min_val_reg;
        end
        else
        begin
            mem_we = 1'b0;
            mem_wa = scan_reg;
            mem_wd = value;
        end
    end

    assign mem_re = cmd.scan_rd || cmd.emit_rd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[scan_reg];
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.clr_set)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
        else if (cmd.store_in)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + ssort_pkg::CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        outer_next = outer_reg;
        if (cmd.clr_set)
        begin
            outer_next = '0;
        end
        else if (cmd.swap_b)
        begin
            outer_next = outer_reg + ssort_pkg::IDX_W'(1);
        end
    end

    always_comb
    begin
        scan_next = scan_reg;
        priority if (cmd.emit_init)
        begin
            scan_next = '0;
        end
        else if (cmd.pass_init)
        begin
            scan_next = outer_reg;
        end
        else if (cmd.swap_b)
        begin
            scan_next = outer_reg + ssort_pkg::IDX_W'(1);
        end
        else if (cmd.scan_rd || cmd.out_load)
        begin
            scan_next = scan_reg + ssort_pkg::IDX_W'(1);
        end
        else
        begin
            scan_next = scan_reg;
        end
    end

    // running minimum; the first element of a pass seeds it, ties keep the earlier one
    always_comb
    begin
        min_val_next   = min_val_reg;
        min_pos_next   = min_pos_reg;
        outer_val_next = outer_val_reg;
        if (rd_vld_reg)
        begin
            if (rd_first_reg)
            begin
                min_val_next   = rd_data_reg;
                min_pos_next   = rd_pos_reg;
                outer_val_next = rd_data_reg;
            end
            else if (rd_data_reg < min_val_reg)
            begin
                min_val_next = rd_data_reg;
                min_pos_next = rd_pos_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            outer_reg     <= '0;
            scan_reg      <= '0;
            min_pos_reg   <= '0;
            dropped_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            outer_reg     <= outer_next;
            scan_reg      <= scan_next;
            min_pos_reg   <= min_pos_next;
            dropped_reg   <= dropped_next;
            rd_vld_reg    <= cmd.scan_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_first_reg  <= (scan_reg == outer_reg);
        rd_pos_reg    <= scan_reg;
        min_val_reg   <= min_val_next;
        outer_val_reg <= outer_val_next;
        if (cmd.out_load)
        begin
            value_res_reg <= rd_data_reg;
            last_res_reg  <= sts.scan_end;
            overflow_reg  <= dropped_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_res = value_res_reg;
    assign last_res  = last_res_reg;
    assign overflow  = overflow_reg;

    `SSORT_ASSERT_IMPL(a_count_bound, 1'b1,
        count_reg <= ssort_pkg::CNT_W'(ssort_pkg::MAX_ELEMENTS), "element count past capacity")
    `SSORT_ASSERT_IMPL(a_rd_in_set, rd_vld_reg, rd_pos_reg <= last_idx,
        "scan read beyond stored set")
    `SSORT_ASSERT_IMPL(a_min_in_range, cmd.swap_a,
        (min_pos_reg >= outer_reg) && (min_pos_reg <= last_idx), "minimum outside unsorted part")
    `SSORT_ASSERT_NEXT(a_next_pass, cmd.swap_b && !sts.outer_end, scan_reg == outer_reg,
        "next pass does not start at new outer position")

endmodule

`default_nettype wire

### rtl/selection_sort_engine_core.sv
// ----------------------------------------------------------------------------
// selection_sort_engine_core
// collects a set of signed words, sorts ascending by selection sort, emits it
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | value[31:0] signed, last
//  out     | out_valid / out_stall| value_res[31:0] signed, last_res, overflow
//
//  collect takes one transfer per cycle; the set is sorted once last arrives
//  sort of n elements: one pass per position but the last; each pass scans
//  the unsorted part through the single read port of the store, then swaps
//  emit reads each result, then loads it once out_stall frees the output
//  in_stall is high from the last transfer until the last result is loaded
//  reset clears counters and control; store contents stay undefined
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module selection_sort_engine_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [ssort_pkg::DATA_W-1:0] value,
    input  wire logic                                last,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [ssort_pkg::DATA_W-1:0]      value_res,
    output logic                                     last_res,
    output logic                                     overflow
);

    ssort_pkg::cmd_t cmd;
    ssort_pkg::sts_t sts;

    ssort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    ssort_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .value     (value),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .value_res (value_res),
        .last_res  (last_res),
        .overflow  (overflow)
    );

endmodule

`default_nettype wire

### test/selection_sort_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selection_sort_engine_core_tb
// feeds sets of signed words into the sort engine and checks every sorted
// word, its last mark and its overflow flag against a behavioral sorter;
// a short directed table comes first, then random sets of random sizes,
// including a full store and sets that overrun it
// ----------------------------------------------------------------------------
module selection_sort_engine_core_tb;

    localparam int DEPTH        = ssort_pkg::MAX_ELEMENTS;
    localparam int W            = ssort_pkg::DATA_W;
    localparam int RANDOM_ITEMS = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [W-1:0] MAX_WORD = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] MIN_WORD = 32'sh8000_0000;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                last;
        logic                ovf;
    } sorted_word_t;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                last;
        logic                typed;
        logic signed [W-1:0] want_value;
        logic                want_ovf;
    } stim_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic signed [W-1:0] value     = '0;
    logic                last      = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic signed [W-1:0] value_res;
    logic                last_res;
    logic                overflow;

    // behavioral copy of the sorter state
    logic signed [W-1:0] shadow_store [DEPTH];
    int                  shadow_count   = 0;
    bit                  shadow_dropped = 1'b0;

    sorted_word_t sorted_pending [$];
    sorted_word_t want_word;

    int errors      = 0;
    int cycle_count = 0;
    int stall_pct   = 0;
    int stall_left  = 0;

    selection_sort_engine_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value_res (value_res),
        .last_res  (last_res),
        .overflow  (overflow)
    );

    always #4 clk = ~clk;

    // stores one element and, when it closes the set, queues the sorted set
    function automatic int predict_sorted_set(input logic signed [W-1:0] v, input logic l);
        int                  n;
        int                  pos;
        int                  scan;
        int                  lo;
        logic signed [W-1:0] tmp;
        sorted_word_t        r;
        if (shadow_count < DEPTH)
        begin
            shadow_store[shadow_count] = v;
            shadow_count++;
        end
        else
        begin
            shadow_dropped = 1'b1;
        end
        if (!l)
            return 0;
        n = shadow_count;
        for (pos = 0; pos + 1 < n; pos++)
        begin
            lo = pos;
            // strict less-than keeps the first minimum on a tie
            for (scan = pos + 1; scan < n; scan++)
                if (shadow_store[scan] < shadow_store[lo])
                    lo = scan;
            tmp                = shadow_store[lo];
            shadow_store[lo]   = shadow_store[pos];
            shadow_store[pos]  = tmp;
        end
        for (pos = 0; pos < n; pos++)
        begin
            r.value = shadow_store[pos];
            r.last  = (pos == n - 1);
            r.ovf   = shadow_dropped;
            sorted_pending.push_back(r);
        end
        shadow_count   = 0;
        shadow_dropped = 1'b0;
        return n;
    endfunction

    function automatic logic signed [W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom;
        else if (sel < 8)
            return int'($urandom_range(0, 8)) - 4;
        else if (sel == 8)
            return MIN_WORD;
        else
            return MAX_WORD;
    endfunction

    // presents one element after an optional gap, waits for its transfer
    task automatic send_element(input logic signed [W-1:0] v, input logic l,
                                input int gap_pct, output int added);
        int gap;
        gap = 0;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 12);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        added = predict_sorted_set(v, l);
    endtask

    // output side: check each transfer, stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (sorted_pending.size() == 0)
            begin
                $error("unexpected result value_res=%0d last_res=%0b overflow=%0b",
                       value_res, last_res, overflow);
                errors++;
            end
            else
            begin
                want_word = sorted_pending.pop_front();
                if (value_res !== want_word.value)
                begin
                    $error("value_res: expected %0d, got %0d", want_word.value, value_res);
                    errors++;
                end
                if (last_res !== want_word.last)
                begin
                    $error("last_res: expected %0b, got %0b", want_word.last, last_res);
                    errors++;
                end
                if (overflow !== want_word.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want_word.ovf, overflow);
                    errors++;
                end
            end
        end
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(1, 12) - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t directed [] = '{
            // single-element sets read straight off: the word itself, last set
            '{MAX_WORD, 1'b1, 1'b1, MAX_WORD, 1'b0},
            '{MIN_WORD, 1'b1, 1'b1, MIN_WORD, 1'b0},
            '{32'sd0,   1'b1, 1'b1, 32'sd0,   1'b0},
            '{-32'sd1,  1'b1, 1'b1, -32'sd1,  1'b0},
            // extremes in reverse order
            '{MAX_WORD, 1'b0, 1'b0, '0, 1'b0},
            '{MIN_WORD, 1'b1, 1'b0, '0, 1'b0},
            // ties
            '{32'sd3,   1'b0, 1'b0, '0, 1'b0},
            '{-32'sd3,  1'b0, 1'b0, '0, 1'b0},
            '{32'sd3,   1'b0, 1'b0, '0, 1'b0},
            '{-32'sd3,  1'b1, 1'b0, '0, 1'b0},
            // descending
            '{32'sd100, 1'b0, 1'b0, '0, 1'b0},
            '{32'sd50,  1'b0, 1'b0, '0, 1'b0},
            '{32'sd0,   1'b0, 1'b0, '0, 1'b0},
            '{-32'sd50, 1'b0, 1'b0, '0, 1'b0},
            '{-32'sd100, 1'b1, 1'b0, '0, 1'b0},
            // all equal
            '{32'sd7,   1'b0, 1'b0, '0, 1'b0},
            '{32'sd7,   1'b0, 1'b0, '0, 1'b0},
            '{32'sd7,   1'b1, 1'b0, '0, 1'b0},
            // already sorted
            '{MIN_WORD, 1'b0, 1'b0, '0, 1'b0},
            '{MAX_WORD, 1'b1, 1'b0, '0, 1'b0},
            // alternating bit patterns
            '{32'sh5555_5555, 1'b0, 1'b0, '0, 1'b0},
            '{32'shAAAA_AAAA, 1'b0, 1'b0, '0, 1'b0},
            '{32'sd1,   1'b1, 1'b0, '0, 1'b0}
        };
        sorted_word_t typed_word;
        int           added;
        int           sent;
        int           set_no;
        int           set_len;
        int           gap_pct;
        int           k;
        bit           quiet;

        repeat (9) @(posedge clk);
        rst_n     <= 1'b1;
        stall_pct <= 20;

        foreach (directed[i])
        begin
            send_element(directed[i].value, directed[i].last, 20, added);
            if (directed[i].typed)
            begin
                // replace the predicted words with the ones typed in the table
                repeat (added) void'(sorted_pending.pop_back());
                typed_word.value = directed[i].want_value;
                typed_word.last  = 1'b1;
                typed_word.ovf   = directed[i].want_ovf;
                sorted_pending.push_back(typed_word);
            end
        end

        sent   = 0;
        set_no = 0;
        quiet  = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            case (set_no)
                2:       set_len = DEPTH;
                5:       set_len = DEPTH + 1;
                8:       set_len = DEPTH + 3 + $urandom_range(0, 4);
                default: set_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24)
                                                                : $urandom_range(1, 8);
            endcase
            quiet = (sent >= RANDOM_ITEMS * 4 / 5);
            if (quiet)
            begin
                gap_pct   = 0;
                stall_pct <= 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 10;
                    default: stall_pct <= 35;
                endcase
            end
            for (k = 0; k < set_len; k++)
                send_element(pick_word(), k == set_len - 1, gap_pct, added);
            sent += set_len;
            set_no++;
        end

        in_valid <= 1'b0;
        while (sorted_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
